/* design/knn_pkg.sv */
// Shared types, constants and codes for the nearest-neighbor insertion list.
package knn_pkg;

    localparam int COORD_BITS     = 24;
    localparam int DIST_BITS      = 50;
    localparam int ID_BITS        = 16;
    localparam int COUNT_BITS     = 5;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int DEF_LIST_DEPTH = 16;

    localparam logic [COUNT_BITS-1:0] MAX_NBR_RESET = COUNT_BITS'(16);

    localparam logic [MODE_BITS-1:0] MODE_START = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_OFFER = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_X   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_Y   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_Z   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_ID  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_NBR = 3'd4;

    typedef struct packed {
        logic [MODE_BITS-1:0]         mode;
        logic [ID_BITS-1:0]           cand_id;
        logic signed [COORD_BITS-1:0] cand_x;
        logic signed [COORD_BITS-1:0] cand_y;
        logic signed [COORD_BITS-1:0] cand_z;
        logic [DIST_BITS-1:0]         start_range;
    } item_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]  range_now;
        logic [COUNT_BITS-1:0] count;
        logic                  inserted;
        logic [ID_BITS-1:0]    entry_id;
        logic [DIST_BITS-1:0]  entry_dist;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic load_start;
        logic calc_sum;
        logic do_insert;
        logic read_beat;
        logic emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic read_last;
    } dp_sts_t;

endpackage

/* design/knn_controller.sv */
// Sequencer for the nearest-neighbor list: one-hot state machine issuing datapath commands.
module knn_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [knn_pkg::MODE_BITS-1:0]  mode,
    input  knn_pkg::dp_sts_t               sts,
    output logic                           busy,
    output knn_pkg::ctrl_cmd_t             cmd
);
    import knn_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_SUM    = 6'b000100,
        S_INSERT = 6'b001000,
        S_READ   = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (mode)
                        MODE_START: state_next = S_LOAD;
                        MODE_OFFER: state_next = S_SUM;
                        MODE_READ:  state_next = S_READ;
                        default:    state_next = S_STATUS;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_start = 1'b1;
                state_next     = S_IDLE;
            end
            S_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.do_insert = 1'b1;
                state_next    = S_IDLE;
            end
            S_READ:
            begin
                cmd.read_beat = 1'b1;
                if (sts.read_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STATUS:
            begin
                cmd.emit_status = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not make the block busy");

    a_read_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.read_beat && sts.read_last) |=> !busy)
        else $error("read out did not end after its last beat");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

/* design/knn_datapath.sv */
// Datapath: config registers, distance squaring, sorted list cells, result register.
module knn_datapath #(
    parameter int LIST_DEPTH = knn_pkg::DEF_LIST_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [knn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [knn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  knn_pkg::item_t                      item,
    input  knn_pkg::ctrl_cmd_t                  cmd,
    output knn_pkg::dp_sts_t                    sts,
    output knn_pkg::result_t                    result,
    output logic                                done
);
    import knn_pkg::*;

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int K_W    = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'({DIST_BITS{1'b1}});

    // configuration
    logic signed [COORD_BITS-1:0] own_x_reg;
    logic signed [COORD_BITS-1:0] own_y_reg;
    logic signed [COORD_BITS-1:0] own_z_reg;
    logic [ID_BITS-1:0]           own_id_reg;
    logic [COUNT_BITS-1:0]        max_nbr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_x_reg   <= '0;
            own_y_reg   <= '0;
            own_z_reg   <= '0;
            own_id_reg  <= '0;
            max_nbr_reg <= MAX_NBR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OWN_X:   own_x_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_OWN_Y:   own_y_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_OWN_Z:   own_z_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_OWN_ID:  own_id_reg  <= cfg_data[ID_BITS-1:0];
                CFG_MAX_NBR: max_nbr_reg <= cfg_data[COUNT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // per-axis squares, taken straight from the accepted beat
    logic signed [DIFF_W-1:0] diff [3];
    logic [DIFF_W-1:0]        mag [3];
    logic [SQ_W-1:0]          sq_next [3];
    logic [SQ_W-1:0]          sq_reg [3];
    logic [ID_BITS-1:0]       cand_id_reg;
    logic [DIST_BITS-1:0]     start_range_reg;
    logic [DIST_BITS-1:0]     cand_dist_reg;
    logic [SUM_W-1:0]         sum;

    always_comb
    begin
        diff[0] = DIFF_W'(own_x_reg) - DIFF_W'(item.cand_x);
        diff[1] = DIFF_W'(own_y_reg) - DIFF_W'(item.cand_y);
        diff[2] = DIFF_W'(own_z_reg) - DIFF_W'(item.cand_z);
        for (int a = 0; a < 3; a++)
        begin
            mag[a]     = diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
            sq_next[a] = SQ_W'(mag[a]) * SQ_W'(mag[a]);
        end
        sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sq_reg          <= sq_next;
            cand_id_reg     <= item.cand_id;
            start_range_reg <= item.start_range;
        end
        if (cmd.calc_sum)
        begin
            cand_dist_reg <= (sum > DIST_MAX) ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
        end
    end

    // list state
    logic [DIST_BITS-1:0] ent_dist_reg [LIST_DEPTH];
    logic [ID_BITS-1:0]   ent_id_reg [LIST_DEPTH];
    logic [DIST_BITS-1:0] ent_dist_next [LIST_DEPTH];
    logic [ID_BITS-1:0]   ent_id_next [LIST_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [DIST_BITS-1:0] range_reg;
    logic [DIST_BITS-1:0] range_next;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic [K_W-1:0]        k_eff;
    logic                  eligible;
    logic                  ins_en;
    logic [CNT_W-1:0]      cnt_ins;
    logic [IDX_W-1:0]      pos;
    logic [LIST_DEPTH-1:0] gt;
    logic [DIST_BITS-1:0]  kept_max;

    always_comb
    begin
        k_eff = (K_W'(max_nbr_reg) > K_W'(LIST_DEPTH)) ? K_W'(LIST_DEPTH)
                                                       : K_W'(max_nbr_reg);
        eligible = (cand_id_reg != own_id_reg) && (k_eff != '0)
                   && (cand_dist_reg < range_reg);
        ins_en   = cmd.do_insert && eligible;
        cnt_ins  = (K_W'(count_reg) < k_eff) ? count_reg + CNT_W'(1) : count_reg;
        pos      = IDX_W'(cnt_ins - CNT_W'(1));
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            gt[i] = cand_dist_reg < ent_dist_reg[i];
        end
    end

    assign sts.read_last = (count_reg == '0)
                           || (CNT_W'(rd_idx_reg) + CNT_W'(1) == count_reg);

    // list cells: insert with shift, or rotate during read out
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic                 prev_gt;
        logic [DIST_BITS-1:0] prev_dist;
        logic [ID_BITS-1:0]   prev_id;
        logic [DIST_BITS-1:0] succ_dist;
        logic [ID_BITS-1:0]   succ_id;

        if (i == 0)
        begin : g_head
            assign prev_gt   = 1'b0;
            assign prev_dist = ent_dist_reg[0];
            assign prev_id   = ent_id_reg[0];
        end
        else
        begin : g_body
            assign prev_gt   = gt[i-1];
            assign prev_dist = ent_dist_reg[i-1];
            assign prev_id   = ent_id_reg[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_tail
            assign succ_dist = ent_dist_reg[0];
            assign succ_id   = ent_id_reg[0];
        end
        else
        begin : g_mid
            assign succ_dist = ent_dist_reg[i+1];
            assign succ_id   = ent_id_reg[i+1];
        end

        always_comb
        begin
            ent_dist_next[i] = ent_dist_reg[i];
            ent_id_next[i]   = ent_id_reg[i];
            if (ins_en && (IDX_W'(i) <= pos))
            begin
                if (prev_gt)
                begin
                    ent_dist_next[i] = prev_dist;
                    ent_id_next[i]   = prev_id;
                end
                else if ((IDX_W'(i) == pos) || gt[i])
                begin
                    ent_dist_next[i] = cand_dist_reg;
                    ent_id_next[i]   = cand_id_reg;
                end
            end
            else if (cmd.read_beat)
            begin
                if (CNT_W'(i + 1) == count_reg)
                begin
                    ent_dist_next[i] = ent_dist_reg[0];
                    ent_id_next[i]   = ent_id_reg[0];
                end
                else if (CNT_W'(i + 1) < count_reg)
                begin
                    ent_dist_next[i] = succ_dist;
                    ent_id_next[i]   = succ_id;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            ent_dist_reg[i] <= ent_dist_next[i];
            ent_id_reg[i]   <= ent_id_next[i];
        end
    end

    // largest kept distance after insert sits at the new tail
    always_comb
    begin
        kept_max = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (IDX_W'(i) == pos)
            begin
                kept_max = kept_max | ent_dist_next[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        range_next = range_reg;
        if (cmd.load_start)
        begin
            count_next = '0;
            range_next = start_range_reg;
        end
        else if (ins_en)
        begin
            count_next = cnt_ins;
            if (K_W'(cnt_ins) == k_eff)
            begin
                range_next = kept_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            range_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            range_reg <= range_next;
            if (cmd.read_beat)
            begin
                rd_idx_reg <= sts.read_last ? '0 : rd_idx_reg + IDX_W'(1);
            end
        end
    end

    // result beat
    result_t result_reg;
    result_t result_next;
    logic    done_reg;
    logic    done_next;

    always_comb
    begin
        result_next.range_now  = range_next;
        result_next.count      = COUNT_BITS'(count_next);
        result_next.inserted   = ins_en;
        result_next.entry_id   = '0;
        result_next.entry_dist = '0;
        result_next.last       = cmd.read_beat ? sts.read_last : 1'b1;
        if (cmd.read_beat && (count_reg != '0))
        begin
            result_next.entry_id   = ent_id_reg[0];
            result_next.entry_dist = ent_dist_reg[0];
        end
        done_next = cmd.load_start | cmd.do_insert | cmd.read_beat | cmd.emit_status;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond depth");

    a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> (done && result.last))
        else $error("offer gave no final result beat");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_start |=> (count_reg == '0))
        else $error("start did not clear the list");

endmodule

/* design/k_nearest_neighbor_insert.sv */
// Top level of the k-nearest-neighbor sorted insertion list.
// Start and unused-mode items: one command state (S_LOAD or S_STATUS), then one registered result beat.
// Offer: distance squares at accept, sum in S_SUM, then parallel compare-and-shift in S_INSERT;
// registered result beat; no new item until the block is idle again. Read out: n beats (1 if empty)
// on back-to-back cycles, one beat per rotation of the list cells; receiver cannot stall.
// Async active-low reset clears count, range and config (max_neighbors to 16); no clear pass.
module k_nearest_neighbor_insert #(
    parameter int LIST_DEPTH = knn_pkg::DEF_LIST_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  knn_pkg::item_t                      item,
    output logic                                done,
    output knn_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [knn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [knn_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import knn_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    knn_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    knn_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result),
        .done      (done)
    );

endmodule
